// ===== hw/rtl/mm_pkg.sv =====
// Shared constants, codes and control types of the matrix multiply block.
`default_nettype none

package mm_pkg;

   // Default values of the top level parameters.
   localparam int MAX_DIM_DEFAULT    = 8;
   localparam int DATA_WIDTH_DEFAULT = 32;

   // Fixed field widths of the channels.
   localparam int MODE_W    = 2;
   localparam int INDEX_W   = 3;
   localparam int VALUE_W   = 32;
   localparam int PRODUCT_W = 64;
   localparam int CFG_W     = 4;
   localparam int CSR_IDX_W = 2;

   // Reset value of every size register.
   localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

   // Item modes.
   localparam logic [MODE_W-1:0] MODE_LOAD_A = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LOAD_B = 2'd1;
   localparam logic [MODE_W-1:0] MODE_START  = 2'd2;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_A = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_B = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic wr_a;      // write the loaded item into the A store
      logic wr_b;      // write the loaded item into the B store
      logic issue;     // read one A and one B element for the current k
      logic first;     // this read starts a new dot product
      logic last;      // this read ends the dot product
      logic out_load;  // move the finished sum into the output register
      logic out_last;  // the finished sum is the final element of C
   } mm_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic acc_ready; // a finished dot product waits in the accumulator
      logic out_free;  // the output register can take a new item
   } mm_status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/mm_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module mm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/mm_ctrl.sv =====
// Controller: size registers, load decode and the row, column and k sequencer.
`default_nettype none

module mm_ctrl
   import mm_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEFAULT,
   localparam int IDX_W  = $clog2(MAX_DIM),
   localparam int DIM_W  = $clog2(MAX_DIM + 1)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_stall,
   input  wire logic [MODE_W-1:0]    req_mode,
   input  wire logic [INDEX_W-1:0]   req_row,
   input  wire logic [INDEX_W-1:0]   req_col,
   input  wire logic                 csr_valid,
   output      logic                 csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_wdata,
   input  wire mm_status_type        status,
   output      mm_cmd_type           cmd,
   output      logic [IDX_W-1:0]     idx_i,
   output      logic [IDX_W-1:0]     idx_j,
   output      logic [IDX_W-1:0]     idx_k
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_WAIT
   } state_type;

   state_type        state_ff, state_in;
   logic             req_stall_ff, req_stall_in;
   logic [IDX_W-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [CFG_W-1:0] rows_a_ff, inner_ff, cols_b_ff;
   logic [DIM_W-1:0] nr, nk, nc;
   logic             i_last, j_last, k_last;
   logic             accept;

   // A size of zero acts as one and a size above the store acts as the store size.
   function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] r);
      logic [DIM_W-1:0] d;
      if (r == '0) begin
         d = DIM_W'(1);
      end else if (int'(r) > MAX_DIM) begin
         d = DIM_W'(MAX_DIM);
      end else begin
         d = DIM_W'(r);
      end
      return d;
   endfunction

   // Size registers; writes to an index past the list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff <= CFG_RESET;
         inner_ff  <= CFG_RESET;
         cols_b_ff <= CFG_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ROWS_A: rows_a_ff <= csr_wdata;
            CSR_INNER:  inner_ff  <= csr_wdata;
            CSR_COLS_B: cols_b_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   assign nr = eff_dim(rows_a_ff);
   assign nk = eff_dim(inner_ff);
   assign nc = eff_dim(cols_b_ff);

   assign i_last = (DIM_W'(i_ff) == nr - DIM_W'(1));
   assign j_last = (DIM_W'(j_ff) == nc - DIM_W'(1));
   assign k_last = (DIM_W'(k_ff) == nk - DIM_W'(1));

   assign accept = req_valid && !req_stall_ff;

   // Next state, counters and commands.
   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_mode)
                  MODE_LOAD_A: begin
                     cmd.wr_a = (int'(req_row) < int'(nr)) && (int'(req_col) < int'(nk));
                  end
                  MODE_LOAD_B: begin
                     cmd.wr_b = (int'(req_row) < int'(nk)) && (int'(req_col) < int'(nc));
                  end
                  MODE_START: begin
                     i_in     = '0;
                     j_in     = '0;
                     k_in     = '0;
                     state_in = ST_ISSUE;
                  end
                  default: ;
               endcase
            end
         end
         ST_ISSUE: begin
            cmd.issue = 1'b1;
            cmd.first = (k_ff == '0);
            cmd.last  = k_last;
            if (k_last) begin
               k_in     = '0;
               state_in = ST_WAIT;
            end else begin
               k_in = k_ff + IDX_W'(1);
            end
         end
         ST_WAIT: begin
            if (status.acc_ready && status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_last = i_last && j_last;
               if (j_last) begin
                  j_in = '0;
                  if (i_last) begin
                     state_in = ST_IDLE;
                  end else begin
                     i_in     = i_ff + IDX_W'(1);
                     state_in = ST_ISSUE;
                  end
               end else begin
                  j_in     = j_ff + IDX_W'(1);
                  state_in = ST_ISSUE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      req_stall_in = (state_in != ST_IDLE);
   end

   // State, counters and the registered stall.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_stall_ff <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         req_stall_ff <= req_stall_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
      end
   end

   assign req_stall = req_stall_ff;
   assign idx_i     = i_ff;
   assign idx_j     = j_ff;
   assign idx_k     = k_ff;

   // The input side closes only after a start item.
   a_stall_after_start: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall_ff) |-> $past(req_valid && req_mode == MODE_START))
      else $error("stall rose without a start item");

   // Loads are never decoded while a multiply runs.
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_a || cmd.wr_b) |-> (state_ff == ST_IDLE && !cmd.issue))
      else $error("store write outside idle");

endmodule

`default_nettype wire

// ===== hw/rtl/mm_datapath.sv =====
// Datapath: element stores, multiply and accumulate pipeline, output register.
`default_nettype none

module mm_datapath
   import mm_pkg::*;
#(
   parameter int MAX_DIM    = MAX_DIM_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT,
   localparam int IDX_W     = $clog2(MAX_DIM),
   localparam int DEPTH     = MAX_DIM * MAX_DIM,
   localparam int ADDR_W    = $clog2(DEPTH),
   localparam int WIDE_W    = ADDR_W + INDEX_W + 1
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [INDEX_W-1:0]   req_row,
   input  wire logic [INDEX_W-1:0]   req_col,
   input  wire logic [VALUE_W-1:0]   req_value,
   input  wire mm_cmd_type           cmd,
   input  wire logic [IDX_W-1:0]     idx_i,
   input  wire logic [IDX_W-1:0]     idx_j,
   input  wire logic [IDX_W-1:0]     idx_k,
   output      mm_status_type        status,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   output      logic [INDEX_W-1:0]   rsp_out_row,
   output      logic [INDEX_W-1:0]   rsp_out_col,
   output      logic [PRODUCT_W-1:0] rsp_product,
   output      logic                 rsp_last
);

   logic [WIDE_W-1:0]            wr_wide, a_wide, b_wide;
   logic [DATA_WIDTH-1:0]        a_data, b_data;
   logic                         rd_vld_ff, rd_first_ff, rd_last_ff;
   logic signed [2*DATA_WIDTH-1:0] prod_in, prod_ff;
   logic                         mul_vld_ff, mul_first_ff, mul_last_ff;
   logic [PRODUCT_W-1:0]         prod_ext, acc_ff, acc_in;
   logic                         acc_ready_ff;
   logic                         rsp_valid_ff;
   logic [INDEX_W-1:0]           rsp_row_ff, rsp_col_ff;
   logic [PRODUCT_W-1:0]         rsp_product_ff;
   logic                         rsp_last_ff;
   logic                         out_free;

   // Row-major flat addresses of the load and of the two reads.
   assign wr_wide = WIDE_W'(req_row) * WIDE_W'(MAX_DIM) + WIDE_W'(req_col);
   assign a_wide  = WIDE_W'(idx_i) * WIDE_W'(MAX_DIM) + WIDE_W'(idx_k);
   assign b_wide  = WIDE_W'(idx_k) * WIDE_W'(MAX_DIM) + WIDE_W'(idx_j);

   mm_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_store_a (
      .clock   (clock),
      .wr_en   (cmd.wr_a),
      .wr_addr (wr_wide[ADDR_W-1:0]),
      .wr_data (req_value[DATA_WIDTH-1:0]),
      .rd_addr (a_wide[ADDR_W-1:0]),
      .rd_data (a_data)
   );

   mm_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_store_b (
      .clock   (clock),
      .wr_en   (cmd.wr_b),
      .wr_addr (wr_wide[ADDR_W-1:0]),
      .wr_data (req_value[DATA_WIDTH-1:0]),
      .rd_addr (b_wide[ADDR_W-1:0]),
      .rd_data (b_data)
   );

   // Signed product of the two stored elements.
   assign prod_in  = $signed(a_data) * $signed(b_data);
   assign prod_ext = PRODUCT_W'(prod_ff);

   // Accumulate with wrap at the product width; a new dot product starts from zero.
   assign acc_in = (mul_first_ff ? '0 : acc_ff) + prod_ext;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Pipeline control flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff    <= 1'b0;
         mul_vld_ff   <= 1'b0;
         acc_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_vld_ff  <= cmd.issue;
         mul_vld_ff <= rd_vld_ff;
         if (mul_vld_ff && mul_last_ff) begin
            acc_ready_ff <= 1'b1;
         end else if (cmd.out_load) begin
            acc_ready_ff <= 1'b0;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Pipeline payload and the output register.
   always_ff @(posedge clock) begin
      rd_first_ff  <= cmd.first;
      rd_last_ff   <= cmd.last;
      prod_ff      <= prod_in;
      mul_first_ff <= rd_first_ff;
      mul_last_ff  <= rd_last_ff;
      if (mul_vld_ff) begin
         acc_ff <= acc_in;
      end
      if (cmd.out_load) begin
         rsp_row_ff     <= INDEX_W'(idx_i);
         rsp_col_ff     <= INDEX_W'(idx_j);
         rsp_product_ff <= acc_ff;
         rsp_last_ff    <= cmd.out_last;
      end
   end

   assign status.acc_ready = acc_ready_ff;
   assign status.out_free  = out_free;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_out_row = rsp_row_ff;
   assign rsp_out_col = rsp_col_ff;
   assign rsp_product = rsp_product_ff;
   assign rsp_last    = rsp_last_ff;

   // A sum is moved out only once it is complete and the output has room.
   a_load_ready: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (acc_ready_ff && out_free))
      else $error("output loaded without a finished sum");

   // No new dot product starts while a finished one is still held.
   a_issue_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> !acc_ready_ff)
      else $error("read issued over a pending sum");

   // The final product of a dot product marks the sum ready.
   a_sum_done: assert property (@(posedge clock) disable iff (reset)
      (mul_vld_ff && mul_last_ff) |=> acc_ready_ff)
      else $error("finished sum not flagged");

endmodule

`default_nettype wire

// ===== hw/rtl/matrix_multiply.sv =====
// Loads are taken back to back while no multiply is running.
// A start item emits rows_a*cols_b results, computed by
// the single multiply and accumulate unit that reads one k per cycle.
// The next item is taken in the cycle after the final result enters the output register.
// Reset clears control state and sets all size registers to 8.
// Element stores are not cleared: entries are undefined until loaded.
`default_nettype none

module matrix_multiply
   import mm_pkg::*;
#(
   parameter int MAX_DIM    = MAX_DIM_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_stall,
   input  wire logic [MODE_W-1:0]    req_mode,
   input  wire logic [INDEX_W-1:0]   req_row,
   input  wire logic [INDEX_W-1:0]   req_col,
   input  wire logic [VALUE_W-1:0]   req_value,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   output      logic [INDEX_W-1:0]   rsp_out_row,
   output      logic [INDEX_W-1:0]   rsp_out_col,
   output      logic [PRODUCT_W-1:0] rsp_product,
   output      logic                 rsp_last,
   input  wire logic                 csr_valid,
   output      logic                 csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_wdata
);

   localparam int IDX_W = $clog2(MAX_DIM);

   mm_cmd_type       cmd;
   mm_status_type    status;
   logic [IDX_W-1:0] idx_i, idx_j, idx_k;

   // Sequencer and size registers.
   mm_ctrl #(
      .MAX_DIM (MAX_DIM)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_mode  (req_mode),
      .req_row   (req_row),
      .req_col   (req_col),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .status    (status),
      .cmd       (cmd),
      .idx_i     (idx_i),
      .idx_j     (idx_j),
      .idx_k     (idx_k)
   );

   // Stores, multiply and accumulate, output register.
   mm_datapath #(
      .MAX_DIM    (MAX_DIM),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_row     (req_row),
      .req_col     (req_col),
      .req_value   (req_value),
      .cmd         (cmd),
      .idx_i       (idx_i),
      .idx_j       (idx_j),
      .idx_k       (idx_k),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_out_row (rsp_out_row),
      .rsp_out_col (rsp_out_col),
      .rsp_product (rsp_product),
      .rsp_last    (rsp_last)
   );

endmodule

`default_nettype wire
